/* src/btr_pkg.sv */
// btr_pkg: constants, types and helpers for the blocked 8x8 transpose engine
// no dependencies; imported by every module and interface of the block

package btr_pkg;

	localparam int TILE       = 8;
	localparam int K_W        = $clog2(TILE);
	localparam int MAX_BLOCKS = 512;
	localparam int BLK_W      = $clog2(MAX_BLOCKS) + 1;
	localparam int IDX_W      = $clog2(MAX_BLOCKS);
	localparam int ELEM_W     = 64;
	localparam int OFF_W      = 24;
	localparam int ROWS_W     = BLK_W + K_W;
	localparam int POS_W      = IDX_W + K_W;
	localparam int CFG_IDX_W  = 2;
	localparam int NBANK      = 2;

	localparam logic [CFG_IDX_W-1:0] REG_ROW_BLOCKS = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_COL_BLOCKS = CFG_IDX_W'(1);

	typedef logic [ELEM_W-1:0] elem_t;

	typedef struct packed {
		logic [OFF_W-1:0]  base;
		logic [ROWS_W-1:0] rows;
		logic              mlast;
	} tile_meta_t;

	typedef struct packed {
		logic            valid;
		logic [K_W-1:0]  k;
		tile_meta_t      meta;
	} rd_req_t;

	// zero counts as one block, anything past the limit is clamped
	function automatic logic [BLK_W-1:0] eff_blocks(input logic [BLK_W-1:0] v);
		logic [BLK_W-1:0] r;
		r = v;
		if (v == '0)
			r = BLK_W'(1);
		else if (v > BLK_W'(MAX_BLOCKS))
			r = BLK_W'(MAX_BLOCKS);
		return r;
	endfunction

endpackage

/* src/btr_if.sv */
// btr_in_if, btr_out_if, btr_cfg_if: valid/ready channels of the transpose engine
// depends on btr_pkg

interface btr_in_if import btr_pkg::*; ();
	logic  valid;
	logic  ready;
	elem_t elem_0;
	elem_t elem_1;
	elem_t elem_2;
	elem_t elem_3;
	elem_t elem_4;
	elem_t elem_5;
	elem_t elem_6;
	elem_t elem_7;

	modport source (output valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
		elem_7, input ready);
	modport sink (input valid, elem_0, elem_1, elem_2, elem_3, elem_4, elem_5, elem_6,
		elem_7, output ready);
endinterface

interface btr_out_if import btr_pkg::*; ();
	logic             valid;
	logic             ready;
	elem_t            out_0;
	elem_t            out_1;
	elem_t            out_2;
	elem_t            out_3;
	elem_t            out_4;
	elem_t            out_5;
	elem_t            out_6;
	elem_t            out_7;
	logic [OFF_W-1:0] dest_offset;
	logic             tile_last;
	logic             matrix_last;

	modport source (output valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
		dest_offset, tile_last, matrix_last, input ready);
	modport sink (input valid, out_0, out_1, out_2, out_3, out_4, out_5, out_6, out_7,
		dest_offset, tile_last, matrix_last, output ready);
endinterface

interface btr_cfg_if import btr_pkg::*; ();
	logic                 valid;
	logic                 ready;
	logic [CFG_IDX_W-1:0] index;
	logic [BLK_W-1:0]     data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

/* src/btr_lane.sv */
// btr_lane: one tile row held in a ping-pong pair of 8-word banks
// depends on btr_pkg; eight copies sit in blocked_transpose_8x8

module btr_lane import btr_pkg::*; (
	input  logic                     clk,
	input  logic                     wr_en,
	input  logic [$clog2(NBANK)-1:0] wr_bank,
	input  elem_t                    wr_row [TILE],
	input  logic [$clog2(NBANK)-1:0] rd_bank,
	input  logic [K_W-1:0]           rd_k,
	output elem_t                    rd_data
);

	elem_t mem_q [NBANK][TILE];

	always_ff @(posedge clk) begin
		if (wr_en) begin
			for (int c = 0; c < TILE; c++)
				mem_q[wr_bank][c] <= wr_row[c];
		end
	end

	assign rd_data = mem_q[rd_bank][rd_k];

endmodule

/* src/btr_pos.sv */
// btr_pos: block count registers, tile position counters and tile base offset
// depends on btr_pkg

module btr_pos import btr_pkg::*; (
	input  logic           clk,
	input  logic           arst_n,
	btr_cfg_if.sink        cfg,
	input  logic           in_fire,
	output logic [K_W-1:0] row,
	output logic           tile_done,
	output tile_meta_t     meta
);

	logic [BLK_W-1:0]  row_blocks_q, col_blocks_q;
	logic [K_W-1:0]    row_q;
	logic [IDX_W-1:0]  rbi_q, cbi_q;
	logic [BLK_W-1:0]  rb, cb;
	logic              last_col, last_row;
	logic [POS_W-1:0]  i_min, j_min;
	logic [OFF_W:0]    prod;

	assign cfg.ready = 1'b1;

	assign rb       = eff_blocks(row_blocks_q);
	assign cb       = eff_blocks(col_blocks_q);
	assign last_col = ({1'b0, cbi_q} + BLK_W'(1)) >= cb;
	assign last_row = ({1'b0, rbi_q} + BLK_W'(1)) >= rb;
	assign i_min    = {rbi_q, K_W'(0)};
	assign j_min    = {cbi_q, K_W'(0)};
	assign prod     = (OFF_W+1)'(j_min) * (OFF_W+1)'(meta.rows);

	assign meta.rows  = {rb, K_W'(0)};
	assign meta.base  = prod[OFF_W-1:0] + OFF_W'(i_min);
	assign meta.mlast = last_col && last_row;

	assign row       = row_q;
	assign tile_done = in_fire && (row_q == K_W'(TILE - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_blocks_q <= BLK_W'(1);
			col_blocks_q <= BLK_W'(1);
		end else if (cfg.valid) begin
			if (cfg.index == REG_ROW_BLOCKS)
				row_blocks_q <= cfg.data;
			else if (cfg.index == REG_COL_BLOCKS)
				col_blocks_q <= cfg.data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			row_q <= '0;
			rbi_q <= '0;
			cbi_q <= '0;
		end else if (in_fire) begin
			row_q <= row_q + K_W'(1);
			if (tile_done) begin
				if (last_col) begin
					cbi_q <= '0;
					rbi_q <= last_row ? '0 : rbi_q + IDX_W'(1);
				end else begin
					cbi_q <= cbi_q + IDX_W'(1);
				end
			end
		end
	end

endmodule

/* src/btr_merge.sv */
// btr_merge: gathers one column from the eight lanes with its offset and end marks
// into the output register; depends on btr_pkg and btr_out_if

module btr_merge import btr_pkg::*; (
	input  logic    clk,
	input  logic    arst_n,
	input  rd_req_t rd,
	input  elem_t   lane_data [TILE],
	output logic    adv,
	btr_out_if.source dst
);

	logic                  valid_q;
	logic [2*K_W+ROWS_W:0] kr;
	logic [OFF_W-1:0]      off;

	assign adv = rd.valid && (!valid_q || dst.ready);
	assign kr  = (2*K_W+ROWS_W+1)'(rd.k) * (2*K_W+ROWS_W+1)'(rd.meta.rows);
	assign off = rd.meta.base + OFF_W'(kr);

	assign dst.valid = valid_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_q <= 1'b0;
		else if (adv)
			valid_q <= 1'b1;
		else if (dst.ready)
			valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			dst.out_0       <= lane_data[0];
			dst.out_1       <= lane_data[1];
			dst.out_2       <= lane_data[2];
			dst.out_3       <= lane_data[3];
			dst.out_4       <= lane_data[4];
			dst.out_5       <= lane_data[5];
			dst.out_6       <= lane_data[6];
			dst.out_7       <= lane_data[7];
			dst.dest_offset <= off;
			dst.tile_last   <= (rd.k == K_W'(TILE - 1));
			dst.matrix_last <= (rd.k == K_W'(TILE - 1)) && rd.meta.mlast;
		end
	end

endmodule

/* src/blocked_transpose_8x8.sv */
// blocked_transpose_8x8: 8x8 tile transpose, eight row lanes with ping-pong banks
// first column: output register loads it after the eighth row marks the bank full
// throughput: one row in and one column out per cycle unless the banks or dst stall
// reset: counters cleared, both block counts 1, banks empty; tile data not cleared
// depends on btr_pkg, btr_if, btr_lane, btr_pos, btr_merge

module blocked_transpose_8x8 import btr_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	btr_cfg_if.sink   cfg,
	btr_in_if.sink    src,
	btr_out_if.source dst
);

	localparam int BK_W = $clog2(NBANK);

	logic             in_fire, tile_done, adv;
	logic [K_W-1:0]   row;
	tile_meta_t       meta;
	logic [NBANK-1:0] full_q;
	logic [NBANK-1:0] full_d;
	logic [BK_W-1:0]  wr_bank_q, rd_bank_q;
	logic [K_W-1:0]   rd_k_q;
	tile_meta_t       meta_q [NBANK];
	elem_t            wr_row [TILE];
	elem_t            lane_data [TILE];
	rd_req_t          rd;

	assign src.ready = !full_q[wr_bank_q];
	assign in_fire   = src.valid && src.ready;

	assign wr_row[0] = src.elem_0;
	assign wr_row[1] = src.elem_1;
	assign wr_row[2] = src.elem_2;
	assign wr_row[3] = src.elem_3;
	assign wr_row[4] = src.elem_4;
	assign wr_row[5] = src.elem_5;
	assign wr_row[6] = src.elem_6;
	assign wr_row[7] = src.elem_7;

	btr_pos u_pos (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.in_fire   (in_fire),
		.row       (row),
		.tile_done (tile_done),
		.meta      (meta)
	);

	for (genvar r = 0; r < TILE; r++) begin : g_lane
		btr_lane u_lane (
			.clk     (clk),
			.wr_en   (in_fire && (row == K_W'(r))),
			.wr_bank (wr_bank_q),
			.wr_row  (wr_row),
			.rd_bank (rd_bank_q),
			.rd_k    (rd_k_q),
			.rd_data (lane_data[r])
		);
	end

	assign rd.valid = full_q[rd_bank_q];
	assign rd.k     = rd_k_q;
	assign rd.meta  = meta_q[rd_bank_q];

	btr_merge u_merge (
		.clk       (clk),
		.arst_n    (arst_n),
		.rd        (rd),
		.lane_data (lane_data),
		.adv       (adv),
		.dst       (dst)
	);

	always_ff @(posedge clk) begin
		if (tile_done)
			meta_q[wr_bank_q] <= meta;
	end

	// bank fill on the last row, bank release on the last column
	always_comb begin
		full_d = full_q;
		if (tile_done)
			full_d[wr_bank_q] = 1'b1;
		if (adv && (rd_k_q == K_W'(TILE - 1)))
			full_d[rd_bank_q] = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			full_q    <= '0;
			wr_bank_q <= '0;
			rd_bank_q <= '0;
			rd_k_q    <= '0;
		end else begin
			full_q <= full_d;
			if (tile_done)
				wr_bank_q <= wr_bank_q + BK_W'(1);
			if (adv) begin
				rd_k_q <= rd_k_q + K_W'(1);
				if (rd_k_q == K_W'(TILE - 1))
					rd_bank_q <= rd_bank_q + BK_W'(1);
			end
		end
	end

	a_full_blocks_in: assert property (@(posedge clk) disable iff (!arst_n)
		(full_q == {NBANK{1'b1}}) |-> !src.ready)
		else $error("row accepted with both banks full");

	a_tile_fills_bank: assert property (@(posedge clk) disable iff (!arst_n)
		tile_done |=> full_q[$past(wr_bank_q)])
		else $error("completed tile did not mark its bank full");

	a_drain_frees_bank: assert property (@(posedge clk) disable iff (!arst_n)
		(adv && (rd_k_q == K_W'(TILE - 1))) |=> !full_q[$past(rd_bank_q)])
		else $error("drained bank still marked full");

	a_matrix_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		(dst.valid && dst.matrix_last) |-> dst.tile_last)
		else $error("matrix end mark without tile end mark");

endmodule
